// ===== rtl/lzse_pkg.sv =====
// Package for the LZ77 sequence executor: item codes, status codes,
// register indexes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package lzse_pkg;

    // Item operation codes (low bits of the input tuser).
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_LITERAL = 2'd1,
        OP_MATCH   = 2'd2,
        OP_END     = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CODE = 3'd1,
        ST_BAD_DIST = 3'd2,
        ST_OVERRUN  = 3'd3,
        ST_SHORT    = 3'd4,
        ST_SIZE     = 3'd5,
        ST_EARLIER  = 3'd6
    } t_status;

    // Configuration register indexes.
    localparam logic [0:0] CFG_EXPECTED_SIZE = 1'b0;
    localparam logic [0:0] CFG_REPCODES      = 1'b1;

    localparam int OFS_W = 17;

    // Recent-offset values after a start item.
    localparam logic [OFS_W-1:0] REP1_INIT = 17'd1;
    localparam logic [OFS_W-1:0] REP2_INIT = 17'd4;
    localparam logic [OFS_W-1:0] REP3_INIT = 17'd8;

    // Offset codes when repcodes are on.
    localparam logic [OFS_W-1:0] CODE_NONE = 17'd0;
    localparam logic [OFS_W-1:0] CODE_REP1 = 17'd1;
    localparam logic [OFS_W-1:0] CODE_REP2 = 17'd2;
    localparam logic [OFS_W-1:0] CODE_REP3 = 17'd3;
    localparam logic [OFS_W-1:0] CODE_BIAS = 17'd3;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;     // capture the accepted beat
        logic commit_single; // emit the single result and apply its update
        logic commit_match;  // take the piece: update offsets, arm the copy
        logic rd_issue;      // read the source byte of the next copy
        logic copy_step;     // store and emit the byte just read
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic match_ok;  // held item is a match piece that passes every check
        logic out_free;  // output register can take a beat this cycle
        logic last_byte; // copy in progress is on its final byte
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/lzse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lzse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lzse_ctrl.sv =====
// Controller state machine of the sequence executor.
// Depends on lzse_pkg (command and status structs).
`default_nettype none

module lzse_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire lzse_pkg::t_dp_stat i_stat,
    output lzse_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_MREAD,
        S_MWAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EVAL;
                end
            end
            S_EVAL: begin
                // a good piece needs no output slot to start
                if (i_stat.match_ok) begin
                    o_cmd.commit_match = 1'b1;
                    n_state            = S_MREAD;
                end else if (i_stat.out_free) begin
                    o_cmd.commit_single = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_MREAD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_MWAIT;
            end
            S_MWAIT: begin
                // hold the read data until the output register frees
                if (i_stat.out_free) begin
                    o_cmd.copy_step = 1'b1;
                    n_state         = i_stat.last_byte ? S_IDLE : S_MREAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lzse_dpath.sv =====
// Datapath of the sequence executor: item and block state, offset decode,
// checks, history window and output register.
// Depends on lzse_pkg and lzse_ram.
`default_nettype none

module lzse_dpath #(
    parameter int WINDOW    = 65536,
    parameter int MIN_MATCH = 3,
    parameter int MAX_PIECE = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_addr,
    input  wire logic [31:0]        i_cfg_wdata,
    // item fields
    input  wire lzse_pkg::t_op      i_item_op,
    input  wire logic [7:0]         i_item_lit,
    input  wire logic [16:0]        i_item_code,
    input  wire logic [6:0]         i_item_len,
    input  wire logic               i_item_cont,
    // result beat
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_out_byte,
    output logic                    o_out_bvalid,
    output lzse_pkg::t_status       o_out_status,
    output logic                    o_out_last,
    // control
    input  wire lzse_pkg::t_dp_cmd  i_cmd,
    output lzse_pkg::t_dp_stat      o_stat
);

    localparam int AW  = $clog2(WINDOW);
    localparam int SW  = ((AW + 1 > 17) ? AW + 1 : 17) + 1;
    localparam logic [AW-1:0] WPTR_LAST = AW'(WINDOW - 1);

    // held item
    lzse_pkg::t_op r_op;
    logic [7:0]    r_lit;
    logic [16:0]   r_code;
    logic [6:0]    r_len;
    logic          r_cont;

    // block state
    logic [31:0]   r_produced;
    logic [16:0]   r_rep1, r_rep2, r_rep3;
    logic [16:0]   r_cur_dist;
    logic          r_err;
    logic [AW-1:0] r_wptr;
    logic [6:0]    r_remaining;

    // registers
    logic [31:0]   r_exp_size;
    logic          r_rep_en;

    // output register
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_bvalid;
    lzse_pkg::t_status r_out_status;
    logic              r_out_last;

    // decode results
    logic [16:0]       dec_dist;
    logic [16:0]       n_rep1, n_rep2, n_rep3;
    logic              bad_code, len_bad, dist_bad, m_overrun, l_overrun;
    logic              match_ok, out_free;
    logic [7:0]        s_byte;
    logic              s_bvalid;
    lzse_pkg::t_status s_status;
    logic              s_begin, s_store, s_fail;

    // memory
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic [SW-1:0] w_ext, d_ext;
    logic [AW-1:0] wptr_inc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_item_op;
            r_lit  <= i_item_lit;
            r_code <= i_item_code;
            r_len  <= i_item_len;
            r_cont <= i_item_cont;
        end
    end

    // offset decode and checks on the held item
    always_comb begin
        dec_dist = r_code;
        n_rep1   = r_rep1;
        n_rep2   = r_rep2;
        n_rep3   = r_rep3;
        bad_code = 1'b0;
        if (r_cont) begin
            dec_dist = r_cur_dist;
        end else if (r_rep_en) begin
            priority if (r_code == lzse_pkg::CODE_NONE) begin
                bad_code = 1'b1;
            end else if (r_code == lzse_pkg::CODE_REP1) begin
                dec_dist = r_rep1;
            end else if (r_code == lzse_pkg::CODE_REP2) begin
                dec_dist = r_rep2;
                n_rep2   = r_rep1;
                n_rep1   = r_rep2;
            end else if (r_code == lzse_pkg::CODE_REP3) begin
                dec_dist = r_rep3;
                n_rep3   = r_rep2;
                n_rep2   = r_rep1;
                n_rep1   = r_rep3;
            end else begin
                dec_dist = r_code - lzse_pkg::CODE_BIAS;
                bad_code = ({16'b0, dec_dist} > 33'(WINDOW));
                n_rep3   = r_rep2;
                n_rep2   = r_rep1;
                n_rep1   = dec_dist;
            end
        end
        len_bad = (r_len == 7'd0) || (r_len > 7'(MAX_PIECE))
               || (!r_cont && (r_len < 7'(MIN_MATCH)));
        dist_bad = (dec_dist == 17'd0) || ({16'b0, dec_dist} > 33'(WINDOW))
                || ({15'b0, dec_dist} > r_produced);
        m_overrun = ({1'b0, r_produced} + {26'b0, r_len}) > {1'b0, r_exp_size};
        l_overrun = ({1'b0, r_produced} + 33'd1) > {1'b0, r_exp_size};
        match_ok  = (r_op == lzse_pkg::OP_MATCH) && !r_err && !bad_code
                 && !len_bad && !dist_bad && !m_overrun;
    end

    // single-result outcome
    always_comb begin
        s_byte   = 8'd0;
        s_bvalid = 1'b0;
        s_status = lzse_pkg::ST_OK;
        s_begin  = 1'b0;
        s_store  = 1'b0;
        s_fail   = 1'b0;
        priority if (r_op == lzse_pkg::OP_START) begin
            s_begin = 1'b1;
        end else if (r_err) begin
            s_status = lzse_pkg::ST_EARLIER;
        end else if (r_op == lzse_pkg::OP_LITERAL) begin
            if (l_overrun) begin
                s_fail   = 1'b1;
                s_status = lzse_pkg::ST_OVERRUN;
            end else begin
                s_store  = 1'b1;
                s_byte   = r_lit;
                s_bvalid = 1'b1;
            end
        end else if (r_op == lzse_pkg::OP_END) begin
            if (r_produced != r_exp_size) begin
                s_fail   = 1'b1;
                s_status = lzse_pkg::ST_SIZE;
            end
        end else begin
            s_fail = 1'b1;
            priority if (bad_code) begin
                s_status = lzse_pkg::ST_BAD_CODE;
            end else if (len_bad) begin
                s_status = lzse_pkg::ST_SHORT;
            end else if (dist_bad) begin
                s_status = lzse_pkg::ST_BAD_DIST;
            end else begin
                s_status = lzse_pkg::ST_OVERRUN;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign wptr_inc = (r_wptr == WPTR_LAST) ? '0 : r_wptr + AW'(1);

    // source address: write position minus distance, wrapped into the window
    assign w_ext     = SW'(r_wptr);
    assign d_ext     = SW'(r_cur_dist);
    assign mem_raddr = (w_ext >= d_ext) ? AW'(w_ext - d_ext)
                                        : AW'(w_ext + SW'(WINDOW) - d_ext);
    assign mem_re    = i_cmd.rd_issue;
    assign mem_we    = i_cmd.copy_step || (i_cmd.commit_single && s_store);
    assign mem_wdata = i_cmd.copy_step ? mem_rdata : r_lit;

    lzse_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wptr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_produced  <= '0;
            r_rep1      <= lzse_pkg::REP1_INIT;
            r_rep2      <= lzse_pkg::REP2_INIT;
            r_rep3      <= lzse_pkg::REP3_INIT;
            r_cur_dist  <= '0;
            r_err       <= 1'b0;
            r_wptr      <= '0;
            r_remaining <= '0;
            r_exp_size  <= '0;
            r_rep_en    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    lzse_pkg::CFG_EXPECTED_SIZE: r_exp_size <= i_cfg_wdata;
                    lzse_pkg::CFG_REPCODES:      r_rep_en   <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_cmd.commit_single) begin
                if (s_begin) begin
                    r_produced <= '0;
                    r_rep1     <= lzse_pkg::REP1_INIT;
                    r_rep2     <= lzse_pkg::REP2_INIT;
                    r_rep3     <= lzse_pkg::REP3_INIT;
                    r_cur_dist <= '0;
                    r_err      <= 1'b0;
                    r_wptr     <= '0;
                end
                if (s_store) begin
                    r_produced <= r_produced + 32'd1;
                    r_wptr     <= wptr_inc;
                end
                if (s_fail) begin
                    r_err <= 1'b1;
                end
            end
            if (i_cmd.commit_match) begin
                r_rep1      <= n_rep1;
                r_rep2      <= n_rep2;
                r_rep3      <= n_rep3;
                r_cur_dist  <= dec_dist;
                r_remaining <= r_len;
            end
            if (i_cmd.copy_step) begin
                r_produced  <= r_produced + 32'd1;
                r_wptr      <= wptr_inc;
                r_remaining <= r_remaining - 7'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit_single || i_cmd.copy_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_single) begin
            r_out_byte   <= s_byte;
            r_out_bvalid <= s_bvalid;
            r_out_status <= s_status;
            r_out_last   <= 1'b1;
        end else if (i_cmd.copy_step) begin
            r_out_byte   <= mem_rdata;
            r_out_bvalid <= 1'b1;
            r_out_status <= lzse_pkg::ST_OK;
            r_out_last   <= (r_remaining == 7'd1);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_bvalid = r_out_bvalid;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

    assign o_stat.match_ok  = match_ok;
    assign o_stat.out_free  = out_free;
    assign o_stat.last_byte = (r_remaining == 7'd1);

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load_item, i_cmd.commit_single, i_cmd.commit_match,
                  i_cmd.rd_issue, i_cmd.copy_step}))
        else $error("more than one datapath command at once");

    a_copy_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.copy_step || i_cmd.rd_issue) |-> (r_remaining != 7'd0))
        else $error("copy step with no bytes left in the piece");

    a_src_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_cur_dist != 17'd0) && ({15'b0, r_cur_dist} <= r_produced))
        else $error("history read before the source byte was produced");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit_single || i_cmd.copy_step) |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while still pending");

endmodule

`default_nettype wire

// ===== rtl/lz_sequence_executor_repcodes_top.sv =====
// LZ77 sequence executor with repeat-offset codes: top level.
// Depends on lzse_pkg, lzse_ctrl, lzse_dpath (which holds lzse_ram).
//
// s_axis carries one item per beat: start, literal, match piece or end (tuser[1:0]).
// Each literal and match byte returns as one m_axis beat with tuser[0] set; start,
// a clean end and every error return one beat with tuser[0] clear and the status in
// tuser[3:1]. tlast marks the final beat of an item. Errors are sticky: every item
// but start then answers "earlier error" until the next start.
// Write i_cfg_addr 0 (expected size) or 1 (repcodes enable, bit 0) only while idle.
// Sequence: an item is accepted and evaluated in the next cycle. Start, end, literals
// and failed pieces register their single result once the output register is free;
// a good piece updates the offsets, then for each byte reads the source byte from the
// registered-read history RAM and then writes it back and emits it, so overlapping
// copies stay exact. s_axis_tready is high only between items.
// Reset restores offsets 1, 4, 8, clears count and error flag, expected size 0,
// repcodes enable 1; the history RAM is not cleared, as only bytes written since
// the last start are read. A stalled m_axis holds its beat, the controller waits
// and the copy pauses with the source byte held in the RAM output register.
`default_nettype none

module lz_sequence_executor_repcodes_top #(
    parameter int WINDOW    = 65536,
    parameter int MIN_MATCH = 3,
    parameter int MAX_PIECE = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // literal_byte[7:0], ofs_code[24:8],
                                            // piece_length[31:25]
    input  wire logic [2:0]  s_axis_tuser,  // operation[1:0], continues[2]
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // out_byte[7:0]
    output logic [3:0]       m_axis_tuser,  // byte_valid[0], status[3:1]
    output logic             m_axis_tlast,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);

    lzse_pkg::t_dp_cmd  cmd;
    lzse_pkg::t_dp_stat stat;
    lzse_pkg::t_status  out_status;
    logic               out_bvalid;

    // Sequence the item: capture, evaluate, then copy bytes one by one.
    lzse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lzse_dpath #(
        .WINDOW    (WINDOW),
        .MIN_MATCH (MIN_MATCH),
        .MAX_PIECE (MAX_PIECE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_op    (lzse_pkg::t_op'(s_axis_tuser[1:0])),
        .i_item_lit   (s_axis_tdata[7:0]),
        .i_item_code  (s_axis_tdata[24:8]),
        .i_item_len   (s_axis_tdata[31:25]),
        .i_item_cont  (s_axis_tuser[2]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_byte   (m_axis_tdata),
        .o_out_bvalid (out_bvalid),
        .o_out_status (out_status),
        .o_out_last   (m_axis_tlast),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );

    // Pack the flag and the status into tuser.
    assign m_axis_tuser = {3'(out_status), out_bvalid};

endmodule

`default_nettype wire
